### hdl/lmsd_pkg.sv
// ----------------------------------------------------------------------------
// LED matrix scan package
// Shared constants and types for the column-scanning LED matrix driver.
// ----------------------------------------------------------------------------
package lmsd_pkg;

   localparam int ROWS    = 8;
   localparam int COLUMNS = 8;
   localparam int TENTHS  = 10;

   localparam logic [3:0] ROW_LIMIT    = 4'(ROWS);
   localparam logic [3:0] COLUMN_LIMIT = 4'(COLUMNS);

   localparam logic [1:0] CMD_LOAD  = 2'd0;
   localparam logic [1:0] CMD_START = 2'd1;
   localparam logic [1:0] CMD_TICK  = 2'd2;

   localparam logic       CSR_TICKS   = 1'b0;
   localparam logic       CSR_DIMMING = 1'b1;

   localparam logic [15:0] TICKS_RESET = 16'd250;

   typedef struct packed {
      logic        running;
      logic [15:0] elapsed;
      logic [15:0] ticks;
      logic        dimming;
   } scan_view_type;

endpackage

### hdl/lmsd_pixel_store.sv
// ----------------------------------------------------------------------------
// LED matrix pixel store
// Holds the lit bit and on-time of every pixel, one word per column, and
// reads the column being scanned with a pending write already merged in.
// ----------------------------------------------------------------------------
module lmsd_pixel_store (
   input  logic        clock,
   input  logic        reset,
   input  logic        wr_en,
   input  logic [2:0]  wr_row,
   input  logic [2:0]  wr_column,
   input  logic        wr_lit,
   input  logic [3:0]  wr_on_time,
   input  logic [2:0]  rd_column,
   output logic [7:0]  rd_lit,
   output logic [31:0] rd_bright
);

   logic [7:0]  lit_ff [8];
   logic [31:0] bright_ff [8];
   logic [7:0]  lit_merged;
   logic [31:0] bright_merged;

   always_comb begin
      lit_merged = lit_ff[wr_column];
      lit_merged[wr_row] = wr_lit;
      bright_merged = bright_ff[wr_column];
      bright_merged[{wr_row, 2'b00} +: 4] = wr_on_time;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < 8; c++) begin
            lit_ff[c]    <= '0;
            bright_ff[c] <= '0;
         end
      end else if (wr_en) begin
         lit_ff[wr_column]    <= lit_merged;
         bright_ff[wr_column] <= bright_merged;
      end
   end

   always_comb begin
      if (wr_en && (wr_column == rd_column)) begin
         rd_lit    = lit_merged;
         rd_bright = bright_merged;
      end else begin
         rd_lit    = lit_ff[rd_column];
         rd_bright = bright_ff[rd_column];
      end
   end

endmodule

### hdl/lmsd_row_drive.sv
// ----------------------------------------------------------------------------
// LED matrix row drive
// Computes the row pin levels of the scanned column. With dimming, a row is
// lit while the elapsed ticks stay below on_time * ticks / 10, which is
// tested as on_time * ticks >= 10 * (elapsed + 1) to avoid a divider.
// ----------------------------------------------------------------------------
module lmsd_row_drive (
   input  lmsd_pkg::scan_view_type view,
   input  logic [7:0]              lit,
   input  logic [31:0]             bright,
   output logic [7:0]              row_levels
);

   logic [15:0] ticks_eff;
   logic [16:0] elapsed_next;
   logic [20:0] threshold;
   logic [19:0] on_product;

   assign ticks_eff    = (view.ticks == 16'd0) ? 16'd1 : view.ticks;
   assign elapsed_next = {1'b0, view.elapsed} + 17'd1;
   assign threshold    = 21'(elapsed_next) * 21'(lmsd_pkg::TENTHS);

   always_comb begin
      row_levels = '0;
      on_product = '0;
      for (int r = 0; r < lmsd_pkg::ROWS; r++) begin
         on_product = 20'(bright[r*4 +: 4]) * 20'(ticks_eff);
         row_levels[r] = view.running && lit[r]
                         && (!view.dimming || ({1'b0, on_product} >= threshold));
      end
   end

endmodule

### hdl/led_matrix_scan_dimming.sv
// ----------------------------------------------------------------------------
// LED matrix column scan with per-pixel dimming
// An accepted item passes the input register, then the result register.
// Throughput: one item per cycle unless rsp stalls; every item gives one
// result. Synchronous reset clears the pixel store and scan state, and sets
// ticks_per_column to 250 and dimming_enable to 1; the block is ready at once.
// ----------------------------------------------------------------------------
module led_matrix_scan_dimming (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // row[2:0], column[5:3], pixel_lit[6], on_time[10:7], frames[18:11], zero fill
   input  logic [23:0] req_tdata,
   // cmd[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // row_levels[7:0], column_levels[15:8], busy_res[16], zero fill
   output logic [23:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [15:0] csr_data
);

   logic        in_valid_ff, in_valid_in;
   logic [1:0]  in_cmd_ff;
   logic [2:0]  in_row_ff;
   logic [2:0]  in_column_ff;
   logic        in_lit_ff;
   logic [3:0]  in_on_ff;
   logic [7:0]  in_frames_ff;

   logic [15:0] ticks_ff;
   logic        dimming_ff;

   logic [2:0]  column_ff, column_in;
   logic [15:0] elapsed_ff, elapsed_in;
   logic [8:0]  frames_left_ff, frames_left_in;
   logic        running_ff, running_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [23:0] rsp_data_ff;

   logic        step;
   logic        load_en;
   logic        is_start;
   logic        is_tick;
   logic [2:0]  view_column;
   logic [7:0]  rd_lit;
   logic [31:0] rd_bright;
   logic [7:0]  row_levels;
   logic [7:0]  column_levels;
   logic [15:0] ticks_eff;
   logic [15:0] elapsed_inc;
   logic [3:0]  column_inc;
   lmsd_pkg::scan_view_type view;

   assign step        = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready  = !in_valid_ff || step;
   assign in_valid_in = req_tvalid ? 1'b1 : (step ? 1'b0 : in_valid_ff);
   assign csr_ready   = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= req_tready ? in_valid_in : in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_cmd_ff    <= req_tuser;
         in_row_ff    <= req_tdata[2:0];
         in_column_ff <= req_tdata[5:3];
         in_lit_ff    <= req_tdata[6];
         in_on_ff     <= req_tdata[10:7];
         in_frames_ff <= req_tdata[18:11];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_ff   <= lmsd_pkg::TICKS_RESET;
         dimming_ff <= 1'b1;
      end else if (csr_valid) begin
         case (csr_index)
            lmsd_pkg::CSR_TICKS: begin
               ticks_ff <= csr_data;
            end
            lmsd_pkg::CSR_DIMMING: begin
               dimming_ff <= csr_data[0];
            end
            default: begin
               ticks_ff <= ticks_ff;
            end
         endcase
      end
   end

   assign is_start = (in_cmd_ff == lmsd_pkg::CMD_START);
   assign is_tick  = (in_cmd_ff == lmsd_pkg::CMD_TICK);
   assign load_en  = step && (in_cmd_ff == lmsd_pkg::CMD_LOAD)
                     && ({1'b0, in_row_ff} < lmsd_pkg::ROW_LIMIT)
                     && ({1'b0, in_column_ff} < lmsd_pkg::COLUMN_LIMIT);

   assign view_column  = is_start ? 3'd0 : column_ff;
   assign view.running = is_start ? 1'b1 : running_ff;
   assign view.elapsed = is_start ? 16'd0 : elapsed_ff;
   assign view.ticks   = ticks_ff;
   assign view.dimming = dimming_ff;

   lmsd_pixel_store u_store (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (load_en),
      .wr_row     (in_row_ff),
      .wr_column  (in_column_ff),
      .wr_lit     (in_lit_ff),
      .wr_on_time (in_on_ff),
      .rd_column  (view_column),
      .rd_lit     (rd_lit),
      .rd_bright  (rd_bright)
   );

   lmsd_row_drive u_rows (
      .view       (view),
      .lit        (rd_lit),
      .bright     (rd_bright),
      .row_levels (row_levels)
   );

   assign column_levels = view.running ? (8'd1 << view_column) : 8'd0;

   assign ticks_eff   = (ticks_ff == 16'd0) ? 16'd1 : ticks_ff;
   assign elapsed_inc = elapsed_ff + 16'd1;
   assign column_inc  = {1'b0, column_ff} + 4'd1;

   always_comb begin
      column_in      = column_ff;
      elapsed_in     = elapsed_ff;
      frames_left_in = frames_left_ff;
      running_in     = running_ff;
      if (is_start) begin
         column_in      = 3'd0;
         elapsed_in     = 16'd0;
         frames_left_in = {1'b0, in_frames_ff} + 9'd1;
         running_in     = 1'b1;
      end else if (is_tick && running_ff) begin
         if (elapsed_inc >= ticks_eff) begin
            elapsed_in = 16'd0;
            if (column_inc >= lmsd_pkg::COLUMN_LIMIT) begin
               column_in = 3'd0;
               if (frames_left_ff <= 9'd1) begin
                  frames_left_in = 9'd0;
                  running_in     = 1'b0;
               end else begin
                  frames_left_in = frames_left_ff - 9'd1;
               end
            end else begin
               column_in = column_inc[2:0];
            end
         end else begin
            elapsed_in = elapsed_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff      <= 3'd0;
         elapsed_ff     <= 16'd0;
         frames_left_ff <= 9'd0;
         running_ff     <= 1'b0;
      end else if (step) begin
         column_ff      <= column_in;
         elapsed_ff     <= elapsed_in;
         frames_left_ff <= frames_left_in;
         running_ff     <= running_in;
      end
   end

   assign rsp_valid_in = step ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_data_ff <= {7'd0, running_in, column_levels, row_levels};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

### sim/tb_led_matrix_scan_dimming.sv
// ----------------------------------------------------------------------------
// Testbench for the LED matrix column scan with per-pixel dimming
// Drives load, start, tick and unused command items into the request stream
// and predicts the row and column pin levels and the busy flag of every item
// in a local copy of the pixel store and scan counters. Results are compared
// field by field in order. The run covers directed corner cases and random
// scans under several tick and dimming settings and several idle patterns.
// ----------------------------------------------------------------------------
module tb_led_matrix_scan_dimming;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] CMD_UNUSED = 2'd3;

   typedef struct packed {
      logic [7:0] row_levels;
      logic [7:0] column_levels;
      logic       busy;
   } pin_levels_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_index;
   logic [15:0] csr_data;

   logic [7:0]  lit_store [8];
   logic [3:0]  on_time_store [64];
   logic [2:0]  scan_column;
   logic [15:0] scan_elapsed;
   logic [8:0]  frames_remaining;
   logic        scan_running;
   logic [15:0] cfg_ticks;
   logic        cfg_dimming;

   pin_levels_type expected_levels [$];
   int          error_count;
   int          req_idle_pct;
   int          rsp_stall_pct;

   led_matrix_scan_dimming uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("tb_led_matrix_scan_dimming: FAIL");
      $finish;
   end

   function automatic int unsigned column_ticks();
      return (cfg_ticks == 16'd0) ? 1 : int'(cfg_ticks);
   endfunction

   function automatic pin_levels_type driven_levels();
      pin_levels_type lv;
      logic        bit_on;
      int unsigned limit;
      lv = '0;
      if (scan_running) begin
         for (int r = 0; r < lmsd_pkg::ROWS; r++) begin
            bit_on = lit_store[scan_column][r];
            if (bit_on && cfg_dimming) begin
               limit = on_time_store[r * 8 + scan_column] * column_ticks()
                       / lmsd_pkg::TENTHS;
               if (scan_elapsed >= limit) bit_on = 1'b0;
            end
            lv.row_levels[r] = bit_on;
         end
         lv.column_levels = 8'b1 << scan_column;
      end
      return lv;
   endfunction

   function automatic pin_levels_type predict_levels(logic [1:0] cmd, logic [2:0] row,
         logic [2:0] column, logic lit, logic [3:0] on_time, logic [7:0] frames);
      pin_levels_type lv;
      case (cmd)
         lmsd_pkg::CMD_LOAD: begin
            lit_store[column][row] = lit;
            on_time_store[row * 8 + column] = on_time;
            lv = driven_levels();
         end
         lmsd_pkg::CMD_START: begin
            frames_remaining = frames + 9'd1;
            scan_running = 1'b1;
            scan_column = 3'd0;
            scan_elapsed = 16'd0;
            lv = driven_levels();
         end
         lmsd_pkg::CMD_TICK: begin
            lv = driven_levels();
            if (scan_running) begin
               scan_elapsed = scan_elapsed + 16'd1;
               if (scan_elapsed >= column_ticks()) begin
                  scan_elapsed = 16'd0;
                  scan_column = scan_column + 3'd1;
                  if (scan_column == 3'd0) begin
                     if (frames_remaining > 0) frames_remaining = frames_remaining - 9'd1;
                     if (frames_remaining == 0) scan_running = 1'b0;
                  end
               end
            end
         end
         default: begin
            lv = driven_levels();
         end
      endcase
      lv.busy = scan_running;
      return lv;
   endfunction

   task automatic report_mismatch(string what, int unsigned got, int unsigned want);
      $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      pin_levels_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_levels.size() == 0) begin
            report_mismatch("unexpected item", rsp_tdata, 0);
         end else begin
            want = expected_levels.pop_front();
            if (rsp_tdata[7:0] !== want.row_levels)
               report_mismatch("row_levels", rsp_tdata[7:0], want.row_levels);
            if (rsp_tdata[15:8] !== want.column_levels)
               report_mismatch("column_levels", rsp_tdata[15:8], want.column_levels);
            if (rsp_tdata[16] !== want.busy)
               report_mismatch("busy_res", rsp_tdata[16], want.busy);
         end
      end
   end

   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   task automatic send_item(logic [1:0] cmd, logic [2:0] row, logic [2:0] column,
         logic lit, logic [3:0] on_time, logic [7:0] frames);
      @(negedge clock);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {5'd0, frames, on_time, lit, column, row};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_levels.push_back(predict_levels(cmd, row, column, lit, on_time, frames));
   endtask

   task automatic send_load(logic [2:0] row, logic [2:0] column, logic lit,
         logic [3:0] on_time);
      send_item(lmsd_pkg::CMD_LOAD, row, column, lit, on_time, 8'($urandom));
   endtask

   task automatic send_start(logic [7:0] frames);
      send_item(lmsd_pkg::CMD_START, 3'($urandom), 3'($urandom), 1'($urandom),
                4'($urandom), frames);
   endtask

   task automatic send_ticks(int count);
      repeat (count)
         send_item(lmsd_pkg::CMD_TICK, 3'($urandom), 3'($urandom), 1'($urandom),
                   4'($urandom), 8'($urandom));
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_levels.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(logic index, logic [15:0] value);
      wait_for_results();
      repeat (2) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (index == lmsd_pkg::CSR_TICKS) cfg_ticks = value;
      else cfg_dimming = value[0];
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [3:0] pick_on_time();
      return ($urandom_range(9) < 8) ? 4'($urandom_range(10)) : 4'($urandom_range(15, 11));
   endfunction

   function automatic logic [7:0] pick_frames();
      return ($urandom_range(9) < 9) ? 8'($urandom_range(3)) : 8'($urandom_range(255));
   endfunction

   function automatic logic [15:0] pick_ticks();
      case ($urandom_range(11))
         0: return 16'd0;
         1: return 16'hFFFF;
         2: return 16'd1;
         default: return 16'($urandom_range(16, 2));
      endcase
   endfunction

   task automatic test_idle_items();
      send_ticks(2);
      send_item(CMD_UNUSED, 3'd7, 3'd7, 1'b1, 4'd15, 8'hFF);
      send_load(3'd0, 3'd0, 1'b1, 4'd10);
      send_load(3'd7, 3'd7, 1'b1, 4'd15);
   endtask

   task automatic test_dimmed_column();
      write_csr(lmsd_pkg::CSR_TICKS, 16'd10);
      send_load(3'd1, 3'd0, 1'b1, 4'd0);
      send_load(3'd2, 3'd0, 1'b1, 4'd5);
      send_load(3'd3, 3'd0, 1'b1, 4'd11);
      send_load(3'd4, 3'd1, 1'b1, 4'd3);
      send_start(8'd0);
      send_ticks(12);
      send_load(3'd5, 3'd1, 1'b1, 4'd8);
      send_load(3'd4, 3'd1, 1'b0, 4'd3);
      send_item(CMD_UNUSED, 3'd0, 3'd0, 1'b0, 4'd0, 8'd0);
      send_start(8'd255);
      send_ticks(3);
   endtask

   task automatic test_tick_extremes();
      write_csr(lmsd_pkg::CSR_DIMMING, 16'd0);
      write_csr(lmsd_pkg::CSR_TICKS, 16'd0);
      send_start(8'd0);
      send_ticks(9);
      write_csr(lmsd_pkg::CSR_DIMMING, 16'd1);
      write_csr(lmsd_pkg::CSR_TICKS, 16'hFFFF);
      send_start(8'd1);
      send_ticks(4);
   endtask

   task automatic test_random_scan(int item_count, int send_idle, int recv_idle);
      int sent;
      int choice;
      req_idle_pct = send_idle;
      rsp_stall_pct = recv_idle;
      sent = 0;
      while (sent < item_count) begin
         write_csr(lmsd_pkg::CSR_TICKS, pick_ticks());
         write_csr(lmsd_pkg::CSR_DIMMING, 16'($urandom_range(1)));
         repeat (8) send_load(3'($urandom), 3'($urandom), 1'($urandom), pick_on_time());
         send_start(pick_frames());
         sent += 9;
         repeat (100) begin
            choice = $urandom_range(99);
            if (choice < 8)
               send_load(3'($urandom), 3'($urandom), 1'($urandom), pick_on_time());
            else if (choice < 12) send_start(pick_frames());
            else if (choice < 15)
               send_item(CMD_UNUSED, 3'($urandom), 3'($urandom), 1'($urandom),
                         4'($urandom), 8'($urandom));
            else send_ticks(1);
            if ($urandom_range(99) == 0) wait_for_results();
            sent++;
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      csr_valid = 1'b0;
      csr_index = 1'b0;
      csr_data = '0;
      error_count = 0;
      req_idle_pct = 20;
      rsp_stall_pct = 65;
      for (int c = 0; c < 8; c++) lit_store[c] = '0;
      for (int p = 0; p < 64; p++) on_time_store[p] = '0;
      scan_column = '0;
      scan_elapsed = '0;
      frames_remaining = '0;
      scan_running = 1'b0;
      cfg_ticks = lmsd_pkg::TICKS_RESET;
      cfg_dimming = 1'b1;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_idle_items();
      test_dimmed_column();
      test_tick_extremes();
      test_random_scan(500, 20, 65);
      test_random_scan(500, 65, 20);
      test_random_scan(500, 0, 0);

      wait_for_results();
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_led_matrix_scan_dimming: PASS");
      end else begin
         $display("tb_led_matrix_scan_dimming: FAIL");
      end
      $finish;
   end

endmodule
